// ----- rtl/core/oal_pkg.sv -----
// Shared types and codes for the ordered array list.
package oal_pkg;

	typedef enum logic [2:0] {
		CMD_GET    = 3'd0,
		CMD_SET    = 3'd1,
		CMD_INSERT = 3'd2,
		CMD_DELETE = 3'd3,
		CMD_SEARCH = 3'd4,
		CMD_CLEAR  = 3'd5
	} cmd_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_WRITE,
		CELL_INSERT,
		CELL_DELETE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     at_pos;
		logic     above_pos;
		logic     live;
	} cell_ctl_t;

	typedef struct packed {
		logic [2:0]         command;
		logic [3:0]         position;
		logic signed [31:0] value_in;
	} req_item_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic [3:0]         found_index;
		logic               found;
		logic [4:0]         length;
		logic [1:0]         status;
	} rsp_item_t;

endpackage

// ----- rtl/core/oal_cell.sv -----
// One storage cell of the list: holds an element, shifts with its neighbours, compares the key.
module oal_cell #(
	parameter int ELEM_WIDTH = 32
) (
	input  logic                  clk,
	input  oal_pkg::cell_ctl_t    ctl,
	input  logic [ELEM_WIDTH-1:0] key,
	input  logic [ELEM_WIDTH-1:0] left,
	input  logic [ELEM_WIDTH-1:0] right,
	output logic [ELEM_WIDTH-1:0] data,
	output logic                  match
);
	import oal_pkg::*;

	logic [ELEM_WIDTH-1:0] data_q;
	logic [ELEM_WIDTH-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (ctl.op)
			CELL_HOLD: begin
				data_d = data_q;
			end
			CELL_WRITE: begin
				if (ctl.at_pos) data_d = key;
			end
			CELL_INSERT: begin
				if (ctl.at_pos) data_d = key;
				else if (ctl.above_pos) data_d = left;
			end
			CELL_DELETE: begin
				if (ctl.at_pos || ctl.above_pos) data_d = right;
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data  = data_q;
	assign match = ctl.live && (data_q == key);

endmodule

// ----- rtl/core/oal_find.sv -----
// Lowest set bit of the registered match row, as found flag and low four index bits.
module oal_find #(
	parameter int N = 16
) (
	input  logic [N-1:0] hits,
	output logic         found,
	output logic [3:0]   index
);
	logic [N-1:0] lowest;

	// isolate lowest set bit: one carry chain
	assign lowest = hits & (~hits + N'(1));
	assign found  = |hits;

	always_comb begin
		index = '0;
		for (int i = 0; i < N; i++) begin
			if (lowest[i]) index = index | 4'(i);
		end
	end

endmodule

// ----- rtl/core/ordered_array_list_top.sv -----
// Ordered array list: a row of CAPACITY cells holds the elements, one per cell, with a count
// register beside it. A command is registered on transfer and executed once the next stage is
// free (all cells shift, write or compare at once and the count updates); the search hits
// are encoded as the result moves into the output register, where it sits until taken. One
// command per cycle is sustained while responses are taken, limited by the update of the cell
// row. Reset clears the count and the valid flags; the cells need no clearing. Faults (full
// list, index out of range) come back as a status.
module ordered_array_list_top #(
	parameter int CAPACITY   = 16,
	parameter int ELEM_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  oal_pkg::req_item_t req,
	input  logic               req_valid,
	output logic               req_ready,
	output oal_pkg::rsp_item_t rsp,
	output logic               rsp_valid,
	input  logic               rsp_ready
);
	import oal_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 4) ? CW : 4;

	// stage 1: registered command
	logic                  valid_s1;
	logic [2:0]            cmd_s1;
	logic [3:0]            pos_s1;
	logic [ELEM_WIDTH-1:0] key_s1;
	logic [ELEM_WIDTH-1:0] key_in;

	// stage 2: executed command
	logic                  valid_s2;
	logic [31:0]           vout_s2;
	logic [CAPACITY-1:0]   match_s2;
	logic                  search_s2;
	logic [4:0]            length_s2;
	logic [1:0]            status_s2;

	logic                  out_valid_q;
	rsp_item_t             out_q;

	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_d;

	logic                  out_go;
	logic                  s2_go;
	logic                  s2_free;
	logic                  s1_go;

	cell_op_t              dec_op;
	cell_op_t              exec_op;
	logic                  dec_read;
	logic                  dec_search;
	logic [1:0]            dec_status;

	logic [PW-1:0]         pos_x;
	logic [PW-1:0]         cnt_x;
	logic                  pos_lt;
	logic                  pos_le;
	logic                  full;

	logic [ELEM_WIDTH-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0]   cell_match;
	cell_ctl_t             cell_ctl  [CAPACITY];
	logic [ELEM_WIDTH-1:0] rd_tab    [16];
	logic [ELEM_WIDTH-1:0] rd_elem;
	logic [31:0]           rd_ext;

	logic                  find_found;
	logic [3:0]            find_index;

	// handshake chain
	assign out_go    = !out_valid_q || rsp_ready;
	assign s2_go     = valid_s2 && out_go;
	assign s2_free   = !valid_s2 || out_go;
	assign s1_go     = valid_s1 && s2_free;
	assign req_ready = !valid_s1 || s2_free;

	// key in element width and read value in 32 bits, sign-extended as needed
	generate
		if (ELEM_WIDTH <= 32) begin : g_key_narrow
			assign key_in = req.value_in[ELEM_WIDTH-1:0];
		end else begin : g_key_wide
			assign key_in = {{(ELEM_WIDTH-32){req.value_in[31]}}, req.value_in};
		end
		if (ELEM_WIDTH >= 32) begin : g_rd_wide
			assign rd_ext = rd_elem[31:0];
		end else begin : g_rd_narrow
			assign rd_ext = {{(32-ELEM_WIDTH){rd_elem[ELEM_WIDTH-1]}}, rd_elem};
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_s1 <= req.command;
			pos_s1 <= req.position;
			key_s1 <= key_in;
		end
	end

	assign pos_x  = PW'(pos_s1);
	assign cnt_x  = PW'(count_q);
	assign pos_lt = pos_x < cnt_x;
	assign pos_le = pos_x <= cnt_x;
	assign full   = count_q == CW'(CAPACITY);

	// command decode; full check ahead of index check on insert
	always_comb begin
		dec_op     = CELL_HOLD;
		dec_read   = 1'b0;
		dec_search = 1'b0;
		dec_status = ST_OK;
		count_d    = count_q;
		unique case (cmd_s1)
			CMD_GET: begin
				if (pos_lt) dec_read = 1'b1;
				else dec_status = ST_RANGE;
			end
			CMD_SET: begin
				if (pos_lt) dec_op = CELL_WRITE;
				else dec_status = ST_RANGE;
			end
			CMD_INSERT: begin
				if (full) begin
					dec_status = ST_FULL;
				end else if (pos_le) begin
					dec_op  = CELL_INSERT;
					count_d = count_q + CW'(1);
				end else begin
					dec_status = ST_RANGE;
				end
			end
			CMD_DELETE: begin
				if (pos_lt) begin
					dec_op   = CELL_DELETE;
					dec_read = 1'b1;
					count_d  = count_q - CW'(1);
				end else begin
					dec_status = ST_RANGE;
				end
			end
			CMD_SEARCH: begin
				dec_search = 1'b1;
			end
			CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
				dec_op = CELL_HOLD;
			end
		endcase
	end

	assign exec_op = s1_go ? dec_op : CELL_HOLD;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (s1_go) begin
			count_q <= count_d;
		end
	end

	// cell row
	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			logic [ELEM_WIDTH-1:0] left_data;
			logic [ELEM_WIDTH-1:0] right_data;

			if (i == 0) begin : g_first
				assign left_data = '0;
			end else begin : g_mid_l
				assign left_data = cell_data[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign right_data = cell_data[i];
			end else begin : g_mid_r
				assign right_data = cell_data[i+1];
			end

			assign cell_ctl[i] = '{
				op:        exec_op,
				at_pos:    (PW'(i) == pos_x),
				above_pos: (PW'(i) > pos_x),
				live:      (PW'(i) < cnt_x)
			};

			oal_cell #(
				.ELEM_WIDTH(ELEM_WIDTH)
			) u_cell (
				.clk  (clk),
				.ctl  (cell_ctl[i]),
				.key  (key_s1),
				.left (left_data),
				.right(right_data),
				.data (cell_data[i]),
				.match(cell_match[i])
			);
		end

		// position only reaches the first sixteen cells
		for (genvar j = 0; j < 16; j++) begin : g_rd
			if (j < CAPACITY) begin : g_used
				assign rd_tab[j] = cell_data[j];
			end else begin : g_none
				assign rd_tab[j] = '0;
			end
		end
	endgenerate

	assign rd_elem = rd_tab[pos_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_go;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			vout_s2   <= dec_read ? rd_ext : '0;
			match_s2  <= dec_search ? cell_match : '0;
			search_s2 <= dec_search;
			length_s2 <= 5'(count_d);
			status_s2 <= dec_status;
		end
	end

	oal_find #(
		.N(CAPACITY)
	) u_find (
		.hits (match_s2),
		.found(find_found),
		.index(find_index)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_go) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			out_q.value_out   <= vout_s2;
			out_q.found_index <= search_s2 ? find_index : '0;
			out_q.found       <= search_s2 && find_found;
			out_q.length      <= length_s2;
			out_q.status      <= status_s2;
		end
	end

	assign rsp       = out_q;
	assign rsp_valid = out_valid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && dec_op == CELL_INSERT) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the list by one");

	a_delete_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && dec_op == CELL_DELETE) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("delete did not shrink the list by one");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.found) |-> (out_q.status == ST_OK))
		else $error("search hit reported with error status");

endmodule

// ----- sim/ordered_array_list_top_test.sv -----
// Self-checking testbench for the ordered array list, with randomised command streams.
module ordered_array_list_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import oal_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_ITEMS = 1400;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_AT = 300;
	localparam int HOLD_CYCLES = 400;
	localparam logic [2:0] CMD_SPARE_LO = 3'd6;
	localparam logic [2:0] CMD_SPARE_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	req_item_t req = '0;
	logic req_valid = 1'b0;
	logic req_ready;
	rsp_item_t rsp;
	logic rsp_valid;
	logic rsp_ready = 1'b0;

	ordered_array_list_top #(
		.CAPACITY(LIST_DEPTH),
		.ELEM_WIDTH(32)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp(rsp),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready)
	);

	always #2 clk = ~clk;

	// Shadow of the list contents, updated at each request transfer
	logic [31:0] list_mem [LIST_DEPTH];
	logic [4:0]  list_len = '0;

	req_item_t req_backlog[$];
	rsp_item_t rsp_due[$];

	int errors = 0;
	int req_sent = 0;
	int rsp_seen = 0;
	int n_full = 0;
	int n_range = 0;
	int n_hits = 0;
	int gap_left = 0;
	int stall_left = 0;
	int cycle_count = 0;
	int gen_count = 0;
	logic [31:0] value_pool [8];

	function automatic rsp_item_t list_apply(req_item_t item);
		rsp_item_t r;
		int pos;
		int n;
		r = '0;
		pos = int'(item.position);
		n = int'(list_len);
		case (item.command)
			CMD_GET: begin
				if (pos < n) r.value_out = list_mem[pos];
				else r.status = ST_RANGE;
			end
			CMD_SET: begin
				if (pos < n) list_mem[pos] = item.value_in;
				else r.status = ST_RANGE;
			end
			CMD_INSERT: begin
				if (n >= LIST_DEPTH) begin
					r.status = ST_FULL;
				end else if (pos > n) begin
					r.status = ST_RANGE;
				end else begin
					for (int k = LIST_DEPTH - 1; k > 0; k--)
						if (k > pos && k <= n) list_mem[k] = list_mem[k - 1];
					list_mem[pos] = item.value_in;
					list_len = list_len + 5'd1;
				end
			end
			CMD_DELETE: begin
				if (pos < n) begin
					r.value_out = list_mem[pos];
					for (int k = 0; k < LIST_DEPTH - 1; k++)
						if (k >= pos && k + 1 < n) list_mem[k] = list_mem[k + 1];
					list_len = list_len - 5'd1;
				end else begin
					r.status = ST_RANGE;
				end
			end
			CMD_SEARCH: begin
				for (int k = 0; k < LIST_DEPTH; k++)
					if (!r.found && k < n && list_mem[k] == item.value_in) begin
						r.found = 1'b1;
						r.found_index = k[3:0];
					end
			end
			CMD_CLEAR: list_len = '0;
			default: ;
		endcase
		r.length = list_len;
		return r;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int draw_gap(int longest);
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(11, longest);
	endfunction

	function automatic logic [3:0] pick_pos(int limit);
		if ($urandom_range(0, 99) < 85 && limit > 0) return 4'($urandom_range(0, limit - 1));
		return 4'($urandom_range(0, 15));
	endfunction

	function automatic logic [31:0] pick_value();
		if ($urandom_range(0, 99) < 60) return value_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	// Queue one command and keep the generator's idea of the length in step
	task automatic push_item(logic [2:0] cmd, logic [3:0] pos, logic [31:0] val);
		req_item_t item;
		item.command = cmd;
		item.position = pos;
		item.value_in = val;
		req_backlog.push_back(item);
		case (cmd)
			CMD_INSERT: if (gen_count < LIST_DEPTH && int'(pos) <= gen_count) gen_count++;
			CMD_DELETE: if (int'(pos) < gen_count) gen_count--;
			CMD_CLEAR:  gen_count = 0;
			default: ;
		endcase
	endtask

	task automatic mismatch(string field, logic [31:0] want, logic [31:0] got);
		errors++;
		$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
	endtask

	// Driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else if (!(req_valid && !req_ready)) begin
			if (req_valid) begin
				rsp_due.push_back(list_apply(req));
				req_sent++;
				gap_left = (req_sent % 256 < 64) ? 0 : draw_gap(60);
			end
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (req_backlog.size() != 0) begin
				req <= req_backlog.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Monitor
	always @(posedge clk or negedge arst_n) begin
		rsp_item_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (rsp_due.size() == 0) begin
					errors++;
					$display("%0t: unexpected response, got 0x%0h", $time, rsp);
				end else begin
					want = rsp_due.pop_front();
					if (rsp.value_out !== want.value_out)
						mismatch("value_out", want.value_out, rsp.value_out);
					if (rsp.found_index !== want.found_index)
						mismatch("found_index", 32'(want.found_index), 32'(rsp.found_index));
					if (rsp.found !== want.found)
						mismatch("found", 32'(want.found), 32'(rsp.found));
					if (rsp.length !== want.length)
						mismatch("length", 32'(want.length), 32'(rsp.length));
					if (rsp.status !== want.status)
						mismatch("status", 32'(want.status), 32'(rsp.status));
					if (want.status == ST_FULL) n_full++;
					if (want.status == ST_RANGE) n_range++;
					if (want.found) n_hits++;
				end
				rsp_seen++;
				// one long hold-off so the pipeline backs up into the request side
				if (rsp_seen == HOLD_AT) stall_left = HOLD_CYCLES;
				else if (rsp_seen % 256 >= 128 && rsp_seen % 256 < 192) stall_left = 0;
				else stall_left = draw_gap(40);
			end else if (rsp_ready && stall_left == 0 && $urandom_range(0, 99) < 3) begin
				stall_left = draw_gap(40);
			end
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ordered_array_list_top verification failed");
		$finish;
	end

	initial begin
		int n_random;
		int burst_left;
		int w_ins;
		int w_del;
		int r;
		logic [2:0] cmd;
		logic [3:0] pos;

		value_pool[0] = 32'h8000_0000;
		value_pool[1] = 32'h7fff_ffff;
		value_pool[2] = 32'h0000_0000;
		value_pool[3] = 32'hffff_ffff;
		value_pool[4] = 32'h0000_0001;
		for (int k = 5; k < 8; k++) value_pool[k] = $urandom;

		// Empty list: every indexed access is out of range, search misses
		push_item(CMD_GET, 4'd0, 32'h0);
		push_item(CMD_SET, 4'd0, 32'h1234_5678);
		push_item(CMD_DELETE, 4'd0, 32'h0);
		push_item(CMD_SEARCH, 4'd0, 32'h0);
		push_item(CMD_INSERT, 4'd1, 32'h0);
		push_item(CMD_INSERT, 4'd0, 32'h8000_0000);
		push_item(CMD_INSERT, 4'd1, 32'h7fff_ffff);
		push_item(CMD_INSERT, 4'd0, 32'hffff_ffff);
		push_item(CMD_INSERT, 4'd15, 32'h0);
		push_item(CMD_GET, 4'd0, 32'h0);
		push_item(CMD_GET, 4'd2, 32'h0);
		push_item(CMD_GET, 4'd3, 32'h0);
		push_item(CMD_SET, 4'd1, 32'h5555_5555);
		push_item(CMD_SET, 4'd3, 32'haaaa_aaaa);
		push_item(CMD_SEARCH, 4'd0, 32'h7fff_ffff);
		push_item(CMD_SEARCH, 4'd0, 32'h0000_007b);
		push_item(CMD_DELETE, 4'd1, 32'h0);
		push_item(CMD_DELETE, 4'd15, 32'h0);
		push_item(CMD_SPARE_LO, 4'd15, 32'hffff_ffff);
		push_item(CMD_SPARE_HI, 4'd0, 32'h0);
		push_item(CMD_CLEAR, 4'd0, 32'h0);
		push_item(CMD_GET, 4'd0, 32'h0);

		// Random bursts that grow, shrink or churn the list
		n_random = 0;
		burst_left = 0;
		w_ins = 25;
		w_del = 20;
		while (n_random < RANDOM_ITEMS) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(20, 60);
				case ($urandom_range(0, 2))
					0: begin w_ins = 55; w_del = 8; end
					1: begin w_ins = 10; w_del = 50; end
					default: begin w_ins = 25; w_del = 20; end
				endcase
			end
			burst_left--;
			r = $urandom_range(0, 99);
			if (r < w_ins) cmd = CMD_INSERT;
			else if (r < w_ins + w_del) cmd = CMD_DELETE;
			else if (r == 99) cmd = CMD_CLEAR;
			else if (r == 98) cmd = $urandom_range(0, 1) ? CMD_SPARE_LO : CMD_SPARE_HI;
			else if (r % 3 == 0) cmd = CMD_GET;
			else if (r % 3 == 1) cmd = CMD_SET;
			else cmd = CMD_SEARCH;
			pos = (cmd == CMD_INSERT) ? pick_pos(gen_count + 1) : pick_pos(gen_count);
			push_item(cmd, pos, pick_value());
			n_random++;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_backlog.size() != 0 || req_valid) @(posedge clk);
		while (rsp_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (rsp_due.size() != 0) errors++;

		$display("%0d commands sent, %0d responses checked, %0d mismatches", req_sent,
			rsp_seen, errors);
		$display("%0d full-list and %0d out-of-range statuses, %0d search hits", n_full,
			n_range, n_hits);
		if (errors == 0) begin
			$display("ordered_array_list_top verification clean");
		end else begin
			$display("ordered_array_list_top verification failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/oal_pkg.sv
rtl/core/oal_cell.sv
rtl/core/oal_find.sv
rtl/core/ordered_array_list_top.sv
sim/ordered_array_list_top_test.sv
